/* sv/pwbd_pkg.sv */
package pwbd_pkg;

    localparam int COUNT_W = 14;
    localparam int THR_W   = 14;
    localparam int CMP_W   = (COUNT_W > THR_W) ? COUNT_W : THR_W;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int BITS_PER_BYTE = 8;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_SYNC_LENGTH    = 3'd0,
        REG_ZERO_LENGTH    = 3'd1,
        REG_ONE_LENGTH     = 3'd2,
        REG_SPACE_LENGTH   = 3'd3,
        REG_SLOWDOWN       = 3'd4,
        REG_INVERT_LEVELS  = 3'd5,
        REG_HIGH_THRESHOLD = 3'd6,
        REG_LOW_THRESHOLD  = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        LVL_UNKNOWN = 2'd0,
        LVL_HIGH    = 2'd1,
        LVL_LOW     = 2'd2
    } level_t;

    typedef enum logic [1:0] {
        PH_SYNC  = 2'd0,
        PH_BIT   = 2'd1,
        PH_SPACE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_BYTE      = 2'd0,
        EV_SYNC_ERR  = 2'd1,
        EV_BIT_ERR   = 2'd2,
        EV_SPACE_ERR = 2'd3
    } event_t;

    typedef struct packed {
        logic [7:0] sync_length;
        logic [7:0] zero_length;
        logic [7:0] one_length;
        logic [7:0] space_length;
        logic [4:0] slowdown_factor;
        logic       invert_levels;
        logic [7:0] high_threshold;
        logic [7:0] low_threshold;
    } cfg_t;

endpackage

/* sv/pwbd_regs.sv */
module pwbd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwbd_pkg::ADDR_W-1:0] paddr,
    input  logic [pwbd_pkg::DATA_W-1:0] pwdata,
    output logic [pwbd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pwbd_pkg::cfg_t              cfg
);

    pwbd_pkg::cfg_t       cfg_reg;
    pwbd_pkg::cfg_t       cfg_next;
    pwbd_pkg::reg_index_t idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = pwbd_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                pwbd_pkg::REG_SYNC_LENGTH:    cfg_next.sync_length     = pwdata[7:0];
                pwbd_pkg::REG_ZERO_LENGTH:    cfg_next.zero_length     = pwdata[7:0];
                pwbd_pkg::REG_ONE_LENGTH:     cfg_next.one_length      = pwdata[7:0];
                pwbd_pkg::REG_SPACE_LENGTH:   cfg_next.space_length    = pwdata[7:0];
                pwbd_pkg::REG_SLOWDOWN:       cfg_next.slowdown_factor = pwdata[4:0];
                pwbd_pkg::REG_INVERT_LEVELS:  cfg_next.invert_levels   = pwdata[0];
                pwbd_pkg::REG_HIGH_THRESHOLD: cfg_next.high_threshold  = pwdata[7:0];
                pwbd_pkg::REG_LOW_THRESHOLD:  cfg_next.low_threshold   = pwdata[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pwbd_pkg::REG_SYNC_LENGTH:    prdata = {24'd0, cfg_reg.sync_length};
            pwbd_pkg::REG_ZERO_LENGTH:    prdata = {24'd0, cfg_reg.zero_length};
            pwbd_pkg::REG_ONE_LENGTH:     prdata = {24'd0, cfg_reg.one_length};
            pwbd_pkg::REG_SPACE_LENGTH:   prdata = {24'd0, cfg_reg.space_length};
            pwbd_pkg::REG_SLOWDOWN:       prdata = {27'd0, cfg_reg.slowdown_factor};
            pwbd_pkg::REG_INVERT_LEVELS:  prdata = {31'd0, cfg_reg.invert_levels};
            pwbd_pkg::REG_HIGH_THRESHOLD: prdata = {24'd0, cfg_reg.high_threshold};
            pwbd_pkg::REG_LOW_THRESHOLD:  prdata = {24'd0, cfg_reg.low_threshold};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_length     <= 8'd20;
            cfg_reg.zero_length     <= 8'd3;
            cfg_reg.one_length      <= 8'd10;
            cfg_reg.space_length    <= 8'd3;
            cfg_reg.slowdown_factor <= 5'd1;
            cfg_reg.invert_levels   <= 1'b0;
            cfg_reg.high_threshold  <= 8'd120;
            cfg_reg.low_threshold   <= 8'd110;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/pwbd_slicer.sv */
module pwbd_slicer (
    input  logic           clk,
    input  logic           rst_n,
    input  pwbd_pkg::cfg_t cfg,
    input  logic           accept,
    input  logic [7:0]     sample,
    output logic           push,
    output logic           push_high
);

    pwbd_pkg::level_t level_reg;
    pwbd_pkg::level_t level_next;

    // high test wins when the thresholds overlap
    always_comb
    begin
        level_next = level_reg;
        if (sample >= cfg.high_threshold)
        begin
            level_next = cfg.invert_levels ? pwbd_pkg::LVL_LOW : pwbd_pkg::LVL_HIGH;
        end
        else if (sample <= cfg.low_threshold)
        begin
            level_next = cfg.invert_levels ? pwbd_pkg::LVL_HIGH : pwbd_pkg::LVL_LOW;
        end
    end

    // samples before the first crossing are dropped here
    assign push      = accept && (level_next != pwbd_pkg::LVL_UNKNOWN);
    assign push_high = (level_next == pwbd_pkg::LVL_HIGH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= pwbd_pkg::LVL_UNKNOWN;
        end
        else if (accept)
        begin
            level_reg <= level_next;
        end
    end

endmodule

/* sv/pwbd_queue.sv */
module pwbd_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic push_high,
    input  logic pop,
    output logic has_room,
    output logic head_valid,
    output logic head_high
);

    logic [pwbd_pkg::QDEPTH-1:0] slot_reg;
    logic [pwbd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pwbd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pwbd_pkg::QCNT_W-1:0] fill_reg;
    logic [pwbd_pkg::QCNT_W-1:0] fill_next;
    logic                        do_pop;

    assign has_room   = (fill_reg != pwbd_pkg::QCNT_W'(pwbd_pkg::QDEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_high  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

/* sv/pwbd_phase.sv */
module pwbd_phase (
    input  logic           clk,
    input  logic           rst_n,
    input  pwbd_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  logic           head_high,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic [7:0]     out_byte
);

    pwbd_pkg::phase_t              phase_reg;
    pwbd_pkg::phase_t              phase_next;
    logic [pwbd_pkg::COUNT_W-1:0]  count_reg;
    logic [pwbd_pkg::COUNT_W-1:0]  count_next;
    logic [3:0]                    bit_index_reg;
    logic [3:0]                    bit_index_next;
    logic [7:0]                    shift_reg;
    logic [7:0]                    shift_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    pwbd_pkg::event_t              kind_reg;
    pwbd_pkg::event_t              kind_next;
    logic [7:0]                    byte_reg;
    logic [7:0]                    byte_next;

    logic [pwbd_pkg::THR_W-1:0]    sync_min;
    logic [pwbd_pkg::THR_W-1:0]    zero_min;
    logic [pwbd_pkg::THR_W-1:0]    one_min;
    logic [pwbd_pkg::THR_W-1:0]    one_max;
    logic [pwbd_pkg::THR_W-1:0]    space_min;
    logic [pwbd_pkg::CMP_W-1:0]    cnt;
    logic [pwbd_pkg::COUNT_W-1:0]  count_inc;
    logic [3:0]                    bit_inc;
    logic                          is_sync;
    logic                          sync_ok;
    logic                          one_ok;
    logic                          zero_ok;
    logic                          space_ok;
    logic                          last_bit;
    logic                          bit_done;
    logic                          emit;
    pwbd_pkg::event_t              emit_kind;

    assign sync_min  = pwbd_pkg::THR_W'(cfg.sync_length) * pwbd_pkg::THR_W'(cfg.slowdown_factor);
    assign zero_min  = pwbd_pkg::THR_W'(cfg.zero_length) * pwbd_pkg::THR_W'(cfg.slowdown_factor);
    assign one_min   = pwbd_pkg::THR_W'(cfg.one_length) * pwbd_pkg::THR_W'(cfg.slowdown_factor);
    assign one_max   = {one_min[pwbd_pkg::THR_W-2:0], 1'b0};
    assign space_min = pwbd_pkg::THR_W'(cfg.space_length) * pwbd_pkg::THR_W'(cfg.slowdown_factor);

    assign cnt      = pwbd_pkg::CMP_W'(count_reg);
    assign sync_ok  = cnt >= pwbd_pkg::CMP_W'(sync_min);
    assign one_ok   = (cnt >= pwbd_pkg::CMP_W'(one_min)) && (cnt <= pwbd_pkg::CMP_W'(one_max));
    assign zero_ok  = (cnt >= pwbd_pkg::CMP_W'(zero_min)) && (cnt < pwbd_pkg::CMP_W'(one_min));
    assign space_ok = cnt >= pwbd_pkg::CMP_W'(space_min);

    // counter saturates at all ones
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign bit_inc   = bit_index_reg + 1'b1;
    assign last_bit  = (bit_inc == 4'(pwbd_pkg::BITS_PER_BYTE));
    assign bit_done  = one_ok || zero_ok;
    assign is_sync   = (phase_reg != pwbd_pkg::PH_BIT) && (phase_reg != pwbd_pkg::PH_SPACE);

    // one queued level per cycle as long as the output register can take a result
    assign pop = head_valid && (!out_valid_reg || out_ready);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            case (phase_reg)
                pwbd_pkg::PH_BIT:
                begin
                    if (head_high)
                    begin
                        if (!bit_done || last_bit)
                        begin
                            phase_next = pwbd_pkg::PH_SYNC;
                        end
                        else
                        begin
                            phase_next = pwbd_pkg::PH_SPACE;
                        end
                    end
                end
                pwbd_pkg::PH_SPACE:
                begin
                    if (!head_high)
                    begin
                        phase_next = space_ok ? pwbd_pkg::PH_BIT : pwbd_pkg::PH_SYNC;
                    end
                end
                default:
                begin
                    if (head_high)
                    begin
                        phase_next = pwbd_pkg::PH_SYNC;
                    end
                    else
                    begin
                        phase_next = sync_ok ? pwbd_pkg::PH_BIT : pwbd_pkg::PH_SYNC;
                    end
                end
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        count_next     = count_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        emit           = 1'b0;
        emit_kind      = pwbd_pkg::EV_BYTE;
        if (pop)
        begin
            if (phase_reg == pwbd_pkg::PH_BIT)
            begin
                if (!head_high)
                begin
                    count_next = count_inc;
                end
                else if (bit_done)
                begin
                    if (one_ok && (bit_index_reg < 4'(pwbd_pkg::BITS_PER_BYTE)))
                    begin
                        shift_next = shift_reg | (8'd1 << bit_index_reg[2:0]);
                    end
                    count_next     = pwbd_pkg::COUNT_W'(1);
                    bit_index_next = bit_inc;
                    emit           = last_bit;
                    emit_kind      = pwbd_pkg::EV_BYTE;
                end
                else
                begin
                    count_next = pwbd_pkg::COUNT_W'(1);
                    emit       = 1'b1;
                    emit_kind  = pwbd_pkg::EV_BIT_ERR;
                end
            end
            else if (phase_reg == pwbd_pkg::PH_SPACE)
            begin
                if (head_high)
                begin
                    count_next = count_inc;
                end
                else if (space_ok)
                begin
                    count_next = pwbd_pkg::COUNT_W'(1);
                end
                else
                begin
                    count_next = '0;
                    emit       = 1'b1;
                    emit_kind  = pwbd_pkg::EV_SPACE_ERR;
                end
            end
            else if (is_sync)
            begin
                if (head_high)
                begin
                    count_next = count_inc;
                end
                else if (sync_ok)
                begin
                    count_next     = pwbd_pkg::COUNT_W'(1);
                    bit_index_next = '0;
                    shift_next     = '0;
                end
                else
                begin
                    count_next = '0;
                    emit       = 1'b1;
                    emit_kind  = pwbd_pkg::EV_SYNC_ERR;
                end
            end
        end
    end

    // output register, freed as soon as the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
            byte_next      = (emit_kind == pwbd_pkg::EV_BYTE) ? shift_next : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pwbd_pkg::PH_SYNC;
            count_reg     <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/pulse_width_byte_decoder.sv */
// a result beat is registered in the output register after its sample's level has passed through the level queue
// throughput: one sample per cycle, sustained while the result side keeps tready high
// a 4-entry level queue between the slicer and the phase machine absorbs result stalls
// reset: held level unknown, sync phase, pulse counter, bit index and byte cleared,
// queue and output register empty, registers back to their default values
module pulse_width_byte_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] data_byte
    output logic [1:0]                  m_tuser,   // [1:0] event_kind
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwbd_pkg::ADDR_W-1:0] paddr,
    input  logic [pwbd_pkg::DATA_W-1:0] pwdata,
    output logic [pwbd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    pwbd_pkg::cfg_t cfg;
    logic           accept;
    logic           push;
    logic           push_high;
    logic           pop;
    logic           has_room;
    logic           head_valid;
    logic           head_high;
    logic [1:0]     out_kind;
    logic [7:0]     out_byte;

    assign s_tready = has_room;
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = out_byte;
    assign m_tuser  = out_kind;

    pwbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwbd_slicer u_slicer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .sample    (s_tdata),
        .push      (push),
        .push_high (push_high)
    );

    pwbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_high  (push_high),
        .pop        (pop),
        .has_room   (has_room),
        .head_valid (head_valid),
        .head_high  (head_high)
    );

    pwbd_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_high  (head_high),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte)
    );

endmodule
